>>> hw/rtl/fvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_pkg
// Shared constants and types for the flagged varint decoder.
// ----------------------------------------------------------------------------
package fvd_pkg;

    localparam int unsigned MAX_BYTES = 5;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned SHIFT_W  = 6;

    // byte layout
    localparam logic [7:0] FIRST_VALUE_MASK = 8'h3F;
    localparam logic [7:0] FLAG_MASK        = 8'h40;
    localparam logic [7:0] NEXT_VALUE_MASK  = 8'h7F;
    localparam logic [7:0] CONT_MASK        = 8'h80;

    localparam logic [SHIFT_W-1:0] FIRST_BITS = SHIFT_W'(6);
    localparam logic [SHIFT_W-1:0] NEXT_BITS  = SHIFT_W'(7);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] decoded_value;
        logic               flag_bit;
        logic [LEN_W-1:0]   byte_length;
        status_t            status;
    } result_t;

endpackage

>>> hw/rtl/flagged_varint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flagged_varint_decoder
// Decodes a byte stream of flagged varints into 32-bit values.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   data_byte, buffer_end
//  out      out_valid / out_ready decoded_value, flag_bit, byte_length, status
//
//  one byte per cycle while no finished result is stalled; the per-byte shift-or update sets the rate
//  a result shows once the byte that ends its number has passed the input register and the result register
//  input register and result register let the input run while a result waits
//  out_ready low stalls the input only when a byte that makes a result is held
//  rst_n clears the number in progress and both valid flags
module flagged_varint_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         buffer_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fvd_pkg::VALUE_W-1:0]  decoded_value,
    output logic                         flag_bit,
    output logic [fvd_pkg::LEN_W-1:0]    byte_length,
    output logic [1:0]                   status
);
    import fvd_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;

    logic       emit;
    logic       free;
    logic       step;
    result_t    dec_result;
    result_t    out_result;

    fvd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (s1_byte_reg),
        .buffer_end (s1_end_reg),
        .emit       (emit),
        .result     (dec_result)
    );

    fvd_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && emit),
        .result     (dec_result),
        .free       (free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    always_comb
    begin
        // held byte moves on unless its result has nowhere to go
        step          = s1_valid_reg && (!emit || free);
        in_ready      = !s1_valid_reg || step;
        s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= buffer_end;
        end
    end

    assign decoded_value = out_result.decoded_value;
    assign flag_bit      = out_result.flag_bit;
    assign byte_length   = out_result.byte_length;
    assign status        = 2'(out_result.status);

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step |=> s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_end_reg))
        else $error("held request lost while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input not ready with empty input register");

    a_quiet_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !step)
        else $error("decode step without a held request");
`endif

endmodule

>>> hw/rtl/fvd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_decode
// Per-byte decode step: holds the number in progress and forms the result.
// ----------------------------------------------------------------------------
module fvd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             buffer_end,
    output logic             emit,
    output fvd_pkg::result_t result
);
    import fvd_pkg::*;

    logic [VALUE_W-1:0] partial_value_reg;
    logic [VALUE_W-1:0] partial_value_next;
    logic [LEN_W-1:0]   bytes_seen_reg;
    logic [LEN_W-1:0]   bytes_seen_next;
    logic               held_flag_reg;
    logic               held_flag_next;

    logic               more;
    logic [LEN_W-1:0]   count;
    logic [SHIFT_W-1:0] shift_amt;
    logic [VALUE_W-1:0] add_term;
    logic [VALUE_W-1:0] sum_value;
    logic               sum_flag;
    logic               too_long;

    always_comb
    begin
        more      = (data_byte & CONT_MASK) != 8'h00;
        shift_amt = FIRST_BITS + NEXT_BITS * (SHIFT_W'(bytes_seen_reg) - SHIFT_W'(1));
        // later bytes land above all bits already set, so or equals add
        add_term  = VALUE_W'(data_byte & NEXT_VALUE_MASK) << shift_amt;
        if (bytes_seen_reg == '0)
        begin
            sum_value = VALUE_W'(data_byte & FIRST_VALUE_MASK);
            sum_flag  = (data_byte & FLAG_MASK) != 8'h00;
        end
        else
        begin
            sum_value = partial_value_reg | add_term;
            sum_flag  = held_flag_reg;
        end
        count    = bytes_seen_reg + LEN_W'(1);
        too_long = count >= LEN_W'(MAX_BYTES);
        emit     = !more || too_long || buffer_end;

        result.decoded_value = sum_value;
        result.flag_bit      = sum_flag;
        priority if (!more)
        begin
            result.byte_length = count;
            result.status      = ST_OK;
        end
        else if (too_long)
        begin
            result.byte_length = '0;
            result.status      = ST_TOO_LONG;
        end
        else
        begin
            result.byte_length = '0;
            result.status      = ST_TRUNCATED;
        end
    end

    always_comb
    begin
        partial_value_next = partial_value_reg;
        bytes_seen_next    = bytes_seen_reg;
        held_flag_next     = held_flag_reg;
        if (step)
        begin
            if (emit)
            begin
                partial_value_next = '0;
                bytes_seen_next    = '0;
                held_flag_next     = 1'b0;
            end
            else
            begin
                partial_value_next = sum_value;
                bytes_seen_next    = count;
                held_flag_next     = sum_flag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_value_reg <= '0;
            bytes_seen_reg    <= '0;
            held_flag_reg     <= 1'b0;
        end
        else
        begin
            partial_value_reg <= partial_value_next;
            bytes_seen_reg    <= bytes_seen_next;
            held_flag_reg     <= held_flag_next;
        end
    end

`ifndef SYNTHESIS
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_seen_reg < LEN_W'(MAX_BYTES))
        else $error("bytes_seen out of range");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> bytes_seen_reg == '0 && partial_value_reg == '0)
        else $error("state not cleared after result");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        step && !emit |=> bytes_seen_reg == $past(bytes_seen_reg) + LEN_W'(1))
        else $error("byte count did not advance");

    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.status != ST_OK |-> result.byte_length == '0)
        else $error("error result with nonzero length");
`endif

endmodule

>>> hw/rtl/fvd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvd_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module fvd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fvd_pkg::result_t result,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output fvd_pkg::result_t out_result
);
    import fvd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        free        = !valid_reg || out_ready;
        valid_next  = load || (valid_reg && !out_ready);
        result_next = load ? result : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register overwritten before delivery");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready && !load |=> valid_reg && $stable(result_reg))
        else $error("stalled result changed");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg && result_reg == $past(result))
        else $error("loaded result not presented");
`endif

endmodule
